>>> hdl/bar_pkg.sv
// package for the bump allocator with tail reclaim
// holds sizes, status and state codes, and the entry table word
// no dependencies
package bar_pkg;

    // table and arena sizes
    localparam int MAX_ENTRIES     = 128;
    localparam int MAX_ARENA_BYTES = 4096;
    localparam int IDX_W           = $clog2(MAX_ENTRIES);
    localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
    localparam int BYTE_W          = 13;
    localparam int OFF_W           = 12;
    localparam int SUM_W           = BYTE_W + 1;

    localparam logic [CNT_W-1:0]  ENTRIES_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [BYTE_W-1:0] ARENA_MAX   = BYTE_W'(MAX_ARENA_BYTES);
    localparam logic [BYTE_W-1:0] CAP_RESET   = 13'd128;

    // configuration register byte address
    localparam logic [2:0] CAP_ADDR = 3'd0;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_RANGE    = 3'd4,
        ST_INACTIVE = 3'd5
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE_RD,
        S_FREE_CHK,
        S_SCAN1,
        S_SCAN2,
        S_RESP
    } t_state;

    // one entry table word
    typedef struct packed {
        logic              live;
        logic [BYTE_W-1:0] length;
        logic [OFF_W-1:0]  start;
    } t_entry;

    // operands of the shared add and compare unit
    typedef struct packed {
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] limit;
    } t_alu_op;

endpackage

>>> hdl/bump_allocator_tail_reclaim.sv
// Bump allocator with tail reclaim. An allocate passes through the allocate and response states
// to the load of the result register. A free that reclaims makes two sweeps of the entry table
// through its single read port and the shared add and compare unit (first for a live entry
// starting above the freed one, then for the highest end of the live entries); a free that
// leaves the cursor makes only the first sweep. A free of an empty table or an index out of
// range goes straight to the response state; a free of an inactive entry stops after the read
// and check states. A result still waiting in the result register holds the sequencer in its
// response state. One item is in work at a time; the result register lets the next item be
// taken while a result waits. capacity_bytes sits at byte address 0.
// depends on bar_pkg, bar_alu, bar_table
module bump_allocator_tail_reclaim (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [12:0] i_alloc_size,
    input  logic [6:0]  i_free_index,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [11:0] o_start_offset,
    output logic [6:0]  o_entry_slot,
    output logic        o_reclaimed,
    output logic [12:0] o_used_bytes,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = bar_pkg::IDX_W;
    localparam int CNT_W  = bar_pkg::CNT_W;
    localparam int BYTE_W = bar_pkg::BYTE_W;
    localparam int OFF_W  = bar_pkg::OFF_W;
    localparam int SUM_W  = bar_pkg::SUM_W;

    bar_pkg::t_state  r_state, n_state;
    bar_pkg::t_status r_status, n_status;

    logic [BYTE_W-1:0] r_cap;
    logic [BYTE_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0]  r_used, n_used;
    logic              r_cmd;
    logic [BYTE_W-1:0] r_size;
    logic [IDX_W-1:0]  r_idx;
    logic [OFF_W-1:0]  r_fstart, n_fstart;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic              r_rd_vld, n_rd_vld;
    logic              r_tail, n_tail;
    logic [BYTE_W-1:0] r_top, n_top;
    logic [OFF_W-1:0]  r_start, n_start;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic              r_recl, n_recl;

    logic              r_out_vld;
    bar_pkg::t_status  r_o_status;
    logic [OFF_W-1:0]  r_o_start;
    logic [IDX_W-1:0]  r_o_slot;
    logic              r_o_recl;
    logic [BYTE_W-1:0] r_o_used;

    logic              in_xfer;
    logic              out_take;
    logic              out_load;
    logic              cfg_wr;
    logic [BYTE_W-1:0] eff_cap;
    logic              scan_more;
    logic              alloc_ok;

    bar_pkg::t_alu_op  alu_op;
    logic [SUM_W-1:0]  alu_sum;
    logic              alu_gt;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    bar_pkg::t_entry   mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    bar_pkg::t_entry   mem_q;

    // handshakes
    assign o_stall  = (r_state != bar_pkg::S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_take = r_out_vld && !i_stall;
    assign out_load = (r_state == bar_pkg::S_RESP) && (!r_out_vld || !i_stall);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-BYTE_W){1'b0}}, r_cap};
    assign eff_cap = (r_cap > bar_pkg::ARENA_MAX) ? bar_pkg::ARENA_MAX : r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bar_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[BYTE_W-1:0];
        end
    end

    // operand selection for the shared unit
    always_comb begin
        alu_op = '0;
        case (r_state)
            bar_pkg::S_ALLOC: begin
                alu_op.a     = r_cursor;
                alu_op.b     = r_size;
                alu_op.limit = eff_cap;
            end
            bar_pkg::S_SCAN1: begin
                alu_op.a     = BYTE_W'(mem_q.start);
                alu_op.b     = '0;
                alu_op.limit = BYTE_W'(r_fstart);
            end
            bar_pkg::S_SCAN2: begin
                alu_op.a     = BYTE_W'(mem_q.start);
                alu_op.b     = mem_q.length;
                alu_op.limit = r_top;
            end
            default: begin
                alu_op = '0;
            end
        endcase
    end

    bar_alu u_alu (
        .i_op  (alu_op),
        .o_sum (alu_sum),
        .o_gt  (alu_gt)
    );

    bar_table u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    assign scan_more = (r_addr < r_used);
    assign alloc_ok  = (r_used < bar_pkg::ENTRIES_MAX) && (r_size != '0) && !alu_gt;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bar_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_cmd == bar_pkg::CMD_ALLOC) begin
                        n_state = bar_pkg::S_ALLOC;
                    end else if (r_used == '0 || CNT_W'(i_free_index) >= r_used) begin
                        n_state = bar_pkg::S_RESP;
                    end else begin
                        n_state = bar_pkg::S_FREE_RD;
                    end
                end
            end
            bar_pkg::S_ALLOC:   n_state = bar_pkg::S_RESP;
            bar_pkg::S_FREE_RD: n_state = bar_pkg::S_FREE_CHK;
            bar_pkg::S_FREE_CHK: begin
                n_state = mem_q.live ? bar_pkg::S_SCAN1 : bar_pkg::S_RESP;
            end
            bar_pkg::S_SCAN1: begin
                if (!scan_more && !r_rd_vld) begin
                    n_state = r_tail ? bar_pkg::S_SCAN2 : bar_pkg::S_RESP;
                end
            end
            bar_pkg::S_SCAN2: begin
                if (!scan_more && !r_rd_vld) begin
                    n_state = bar_pkg::S_RESP;
                end
            end
            bar_pkg::S_RESP: begin
                if (out_load) begin
                    n_state = bar_pkg::S_IDLE;
                end
            end
            default: n_state = bar_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb begin
        n_status  = r_status;
        n_cursor  = r_cursor;
        n_used    = r_used;
        n_fstart  = r_fstart;
        n_addr    = r_addr;
        n_rd_vld  = 1'b0;
        n_tail    = r_tail;
        n_top     = r_top;
        n_start   = r_start;
        n_slot    = r_slot;
        n_recl    = r_recl;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_q;
        mem_raddr = r_addr[IDX_W-1:0];
        unique case (r_state)
            bar_pkg::S_IDLE: begin
                n_status = bar_pkg::ST_OK;
                n_start  = '0;
                n_slot   = '0;
                n_recl   = 1'b0;
                if (in_xfer && i_cmd == bar_pkg::CMD_FREE) begin
                    if (r_used == '0) begin
                        n_status = bar_pkg::ST_EMPTY;
                    end else if (CNT_W'(i_free_index) >= r_used) begin
                        n_status = bar_pkg::ST_RANGE;
                    end
                end
            end
            bar_pkg::S_ALLOC: begin
                mem_waddr = r_used[IDX_W-1:0];
                mem_wdata = '{live: 1'b1, length: r_size, start: r_cursor[OFF_W-1:0]};
                if (r_used >= bar_pkg::ENTRIES_MAX) begin
                    n_status = bar_pkg::ST_FULL;
                end else if (!alloc_ok) begin
                    n_status = bar_pkg::ST_NOSPACE;
                end else begin
                    mem_we   = 1'b1;
                    n_start  = r_cursor[OFF_W-1:0];
                    n_slot   = r_used[IDX_W-1:0];
                    n_cursor = alu_sum[BYTE_W-1:0];
                    n_used   = r_used + CNT_W'(1);
                end
            end
            bar_pkg::S_FREE_RD: begin
                mem_raddr = r_idx;
            end
            bar_pkg::S_FREE_CHK: begin
                // retire the entry and start the first sweep
                if (!mem_q.live) begin
                    n_status = bar_pkg::ST_INACTIVE;
                end else begin
                    mem_we         = 1'b1;
                    mem_wdata.live = 1'b0;
                    n_fstart       = mem_q.start;
                    n_addr         = '0;
                    n_tail         = 1'b1;
                end
            end
            bar_pkg::S_SCAN1: begin
                // any live entry above the freed one keeps the cursor
                n_rd_vld = scan_more;
                if (scan_more) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (r_rd_vld && mem_q.live && alu_gt) begin
                    n_tail = 1'b0;
                end
                if (!scan_more && !r_rd_vld) begin
                    n_addr = '0;
                    n_top  = '0;
                end
            end
            bar_pkg::S_SCAN2: begin
                // highest end among live entries
                n_rd_vld = scan_more;
                if (scan_more) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (r_rd_vld && mem_q.live && alu_gt) begin
                    n_top = alu_sum[BYTE_W-1:0];
                end
                if (!scan_more && !r_rd_vld) begin
                    n_cursor = r_top;
                    n_recl   = 1'b1;
                end
            end
            bar_pkg::S_RESP: begin
                n_rd_vld = 1'b0;
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    // control and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bar_pkg::S_IDLE;
            r_cursor <= '0;
            r_used   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_used   <= n_used;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_fstart <= n_fstart;
        r_addr   <= n_addr;
        r_tail   <= n_tail;
        r_top    <= n_top;
        r_start  <= n_start;
        r_slot   <= n_slot;
        r_recl   <= n_recl;
        if (in_xfer) begin
            r_cmd  <= i_cmd;
            r_size <= i_alloc_size;
            r_idx  <= i_free_index;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_start  <= r_start;
            r_o_slot   <= r_slot;
            r_o_recl   <= r_recl;
            r_o_used   <= r_cursor;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_o_status;
    assign o_start_offset = r_o_start;
    assign o_entry_slot   = r_o_slot;
    assign o_reclaimed    = r_o_recl;
    assign o_used_bytes   = r_o_used;

`ifndef SYNTHESIS
    // cursor never runs past the arena
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= bar_pkg::ARENA_MAX)
        else $error("arena cursor beyond arena size");

    // table count never runs past the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= bar_pkg::ENTRIES_MAX)
        else $error("entry count beyond table size");

    // a granted allocate bumps the count by one
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bar_pkg::S_ALLOC && alloc_ok) |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("allocate did not advance entry count");

    // only allocates touch the count, and only frees reclaim
    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bar_pkg::S_ALLOC && r_state != bar_pkg::S_IDLE) |=> $stable(r_used))
        else $error("entry count changed outside allocate");

    // a reclaimed result is always a successful free
    a_recl_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_recl) |-> (r_status == bar_pkg::ST_OK && r_cmd == bar_pkg::CMD_FREE))
        else $error("reclaim flagged on a failed or allocate item");
`endif

endmodule

>>> hdl/bar_alu.sv
// shared add and compare unit of the bump allocator
// forms a + b and flags a sum above the limit
// depends on bar_pkg
module bar_alu (
    input  bar_pkg::t_alu_op           i_op,
    output logic [bar_pkg::SUM_W-1:0]  o_sum,
    output logic                       o_gt
);

    // one wide add and one compare
    always_comb begin
        o_sum = bar_pkg::SUM_W'(i_op.a) + bar_pkg::SUM_W'(i_op.b);
        o_gt  = o_sum > bar_pkg::SUM_W'(i_op.limit);
    end

endmodule

>>> hdl/bar_table.sv
// entry table of the bump allocator
// one write port, one read port with registered data
// depends on bar_pkg
module bar_table (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [bar_pkg::IDX_W-1:0]  i_waddr,
    input  bar_pkg::t_entry            i_wdata,
    input  logic [bar_pkg::IDX_W-1:0]  i_raddr,
    output bar_pkg::t_entry            o_rdata
);

    bar_pkg::t_entry r_mem [bar_pkg::MAX_ENTRIES];
    bar_pkg::t_entry r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
